### rtl/dominant_color_histogram_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dominant color histogram block.
// Both expect clk and arst_n in scope and check only while out of reset.
// ----------------------------------------------------------------------------
`ifndef DOMINANT_COLOR_HISTOGRAM_TOP_DEFINES_SVH
`define DOMINANT_COLOR_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication
`define DCH_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DCH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dch_pkg.sv
// ----------------------------------------------------------------------------
// dch_pkg
// Types, constants and command/status bundles shared by the dominant color
// histogram controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package dch_pkg;

	localparam int BUCKET_STEP_DEF = 24;
	localparam int NUM_TIERS       = 3;
	localparam int COUNT_W         = 12;
	localparam int WORD_W          = COUNT_W * NUM_TIERS;
	localparam int FLOOR_W         = 11;
	localparam int COLOR_W         = 24;
	localparam int CFG_W           = COLOR_W;
	localparam int CFG_IDX_W       = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [FLOOR_W-1:0] STRICT_SAT_RST    = 11'd358;
	localparam logic [FLOOR_W-1:0] STRICT_VALUE_RST  = 11'd205;
	localparam logic [FLOOR_W-1:0] RELAXED_SAT_RST   = 11'd184;
	localparam logic [FLOOR_W-1:0] RELAXED_VALUE_RST = 11'd123;
	localparam logic [FLOOR_W-1:0] LOOSE_SAT_RST     = 11'd82;
	localparam logic [FLOOR_W-1:0] LOOSE_VALUE_RST   = 11'd82;
	localparam logic [COLOR_W-1:0] FALLBACK_RST      = 24'h5B3A8E;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STRICT_SAT    = 3'd0,
		CFG_STRICT_VALUE  = 3'd1,
		CFG_RELAXED_SAT   = 3'd2,
		CFG_RELAXED_VALUE = 3'd3,
		CFG_LOOSE_SAT     = 3'd4,
		CFG_LOOSE_VALUE   = 3'd5,
		CFG_FALLBACK      = 3'd6
	} cfg_reg_t;

	localparam logic [1:0] TIER_STRICT   = 2'd0;
	localparam logic [1:0] TIER_RELAXED  = 2'd1;
	localparam logic [1:0] TIER_LOOSE    = 2'd2;
	localparam logic [1:0] TIER_FALLBACK = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [1:0] tier_used;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // pixel beat accepted this cycle
		logic sweep;      // zero memory at counter, advance counter
		logic scan_rd;    // read memory at counter for the scan
		logic scan_init;  // clear running maxima
		logic out_load;   // load result register
	} dch_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_last;
		logic out_free;
	} dch_sts_t;

endpackage

`default_nettype wire

### rtl/dch_ctrl.sv
// ----------------------------------------------------------------------------
// dch_ctrl
// Sequencer: post-reset clear, pixel intake, end-of-frame scan with clear,
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dch_ctrl
	import dch_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output      logic     in_stall,
	output      dch_cmd_t cmd,
	input  wire dch_sts_t sts
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_RUN    = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_FLUSH  = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.cnt_last) state_d = ST_RUN;
			end
			ST_RUN: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				if (in_valid && in_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last pixel's update lands this cycle
				cmd.scan_init = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.sweep   = 1'b1;
				cmd.scan_rd = 1'b1;
				if (sts.cnt_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

endmodule

`default_nettype wire

### rtl/dch_datapath.sv
// ----------------------------------------------------------------------------
// dch_datapath
// Tier tests, bucket memory with read-modify-write and forwarding, sweep
// counter, running per-tier maxima, config registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dch_datapath
	import dch_pkg::*;
#(
	parameter int BUCKET_STEP = BUCKET_STEP_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pixel_t               in_data,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      result_t              out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire dch_cmd_t             cmd,
	output      dch_sts_t             sts
);

	localparam int LEVELS      = 255 / BUCKET_STEP + 1;
	localparam int NUM_BUCKETS = LEVELS * LEVELS * LEVELS;
	localparam int QW          = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int AW          = $clog2(NUM_BUCKETS);
	localparam int MW          = QW + 8;
	localparam int TW          = 19;

	// ---------------- config registers
	logic [FLOOR_W-1:0] sat_floor_q   [NUM_TIERS];
	logic [FLOOR_W-1:0] value_floor_q [NUM_TIERS];
	logic [COLOR_W-1:0] fallback_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_floor_q[0]   <= STRICT_SAT_RST;
			value_floor_q[0] <= STRICT_VALUE_RST;
			sat_floor_q[1]   <= RELAXED_SAT_RST;
			value_floor_q[1] <= RELAXED_VALUE_RST;
			sat_floor_q[2]   <= LOOSE_SAT_RST;
			value_floor_q[2] <= LOOSE_VALUE_RST;
			fallback_q       <= FALLBACK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STRICT_SAT:    sat_floor_q[0]   <= cfg_data[FLOOR_W-1:0];
				CFG_STRICT_VALUE:  value_floor_q[0] <= cfg_data[FLOOR_W-1:0];
				CFG_RELAXED_SAT:   sat_floor_q[1]   <= cfg_data[FLOOR_W-1:0];
				CFG_RELAXED_VALUE: value_floor_q[1] <= cfg_data[FLOOR_W-1:0];
				CFG_LOOSE_SAT:     sat_floor_q[2]   <= cfg_data[FLOOR_W-1:0];
				CFG_LOOSE_VALUE:   value_floor_q[2] <= cfg_data[FLOOR_W-1:0];
				CFG_FALLBACK:      fallback_q       <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pixel front end
	logic [QW-1:0] qtab [256];

	for (genvar v = 0; v < 256; v++) begin : g_qtab
		assign qtab[v] = QW'(v / BUCKET_STEP);
	end

	logic [7:0]    mx, mn;
	logic [QW-1:0] qr, qg, qb;
	logic [AW-1:0] idx_in;
	logic [TW-1:0] v_lhs, s_lhs;
	logic [TW-1:0] v_rhs [NUM_TIERS];
	logic [TW-1:0] s_rhs [NUM_TIERS];
	logic [NUM_TIERS-1:0] pass;

	always_comb begin
		mx = in_data.red;
		mn = in_data.red;
		if (in_data.green > mx) mx = in_data.green;
		if (in_data.blue  > mx) mx = in_data.blue;
		if (in_data.green < mn) mn = in_data.green;
		if (in_data.blue  < mn) mn = in_data.blue;
	end

	assign qr     = qtab[in_data.red];
	assign qg     = qtab[in_data.green];
	assign qb     = qtab[in_data.blue];
	assign idx_in = AW'((AW'(qr) * AW'(LEVELS) + AW'(qg)) * AW'(LEVELS) + AW'(qb));

	// exact compares: max*1024 >= vf*255, (max-min)*1024 >= sf*max
	assign v_lhs = {1'b0, mx, 10'd0};
	assign s_lhs = {1'b0, 8'(mx - mn), 10'd0};

	for (genvar t = 0; t < NUM_TIERS; t++) begin : g_tier
		assign v_rhs[t] = {value_floor_q[t], 8'd0} - TW'(value_floor_q[t]);
		assign s_rhs[t] = TW'(sat_floor_q[t]) * TW'(mx);
		assign pass[t]  = (v_lhs >= v_rhs[t]) && (s_lhs >= s_rhs[t]);
	end

	logic                 pix_valid_s1;
	logic [AW-1:0]        idx_s1;
	logic [NUM_TIERS-1:0] pass_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pix_valid_s1 <= 1'b0;
		else         pix_valid_s1 <= cmd.take;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_s1  <= idx_in;
			pass_s1 <= pass;
		end
	end

	// ---------------- sweep counter (address plus per-channel digits)
	logic [AW-1:0] addr_q;
	logic [QW-1:0] cr_q, cg_q, cb_q;

	assign sts.cnt_last = (addr_q == AW'(NUM_BUCKETS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cr_q   <= '0;
			cg_q   <= '0;
			cb_q   <= '0;
		end else if (cmd.sweep) begin
			addr_q <= sts.cnt_last ? '0 : addr_q + AW'(1);
			if (cb_q == QW'(LEVELS - 1)) begin
				cb_q <= '0;
				if (cg_q == QW'(LEVELS - 1)) begin
					cg_q <= '0;
					cr_q <= (cr_q == QW'(LEVELS - 1)) ? '0 : cr_q + QW'(1);
				end else begin
					cg_q <= cg_q + QW'(1);
				end
			end else begin
				cb_q <= cb_q + QW'(1);
			end
		end
	end

	// ---------------- bucket memory
	logic [WORD_W-1:0] mem [NUM_BUCKETS];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] base_word, new_word, mem_wd;
	logic [AW-1:0]     mem_ra, mem_wa;
	logic              mem_we;
	logic              lw_valid_q;
	logic [AW-1:0]     lw_addr_q;
	logic [WORD_W-1:0] lw_data_q;

	// previous edge wrote the bucket this pixel read: take that word instead
	assign base_word = (lw_valid_q && lw_addr_q == idx_s1) ? lw_data_q : rd_q;

	always_comb begin
		logic [COUNT_W-1:0] c;
		for (int t = 0; t < NUM_TIERS; t++) begin
			c = base_word[t*COUNT_W +: COUNT_W];
			if (pass_s1[t] && c != COUNT_MAX) c = c + COUNT_W'(1);
			new_word[t*COUNT_W +: COUNT_W] = c;
		end
	end

	assign mem_ra = cmd.scan_rd ? addr_q : idx_in;
	assign mem_we = cmd.sweep || pix_valid_s1;
	assign mem_wa = cmd.sweep ? addr_q : idx_s1;
	assign mem_wd = cmd.sweep ? '0 : new_word;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lw_valid_q <= 1'b0;
		else         lw_valid_q <= pix_valid_s1 && !cmd.sweep;
	end

	always_ff @(posedge clk) begin
		if (pix_valid_s1) begin
			lw_addr_q <= idx_s1;
			lw_data_q <= new_word;
		end
	end

	// ---------------- scan: running maximum per tier, strict > keeps lowest index
	logic          sc_valid_s1;
	logic [QW-1:0] sr_s1, sg_s1, sb_s1;
	logic [COUNT_W-1:0] best_cnt_q [NUM_TIERS];
	logic [QW-1:0]      best_r_q   [NUM_TIERS];
	logic [QW-1:0]      best_g_q   [NUM_TIERS];
	logic [QW-1:0]      best_b_q   [NUM_TIERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sc_valid_s1 <= 1'b0;
		else         sc_valid_s1 <= cmd.scan_rd;
	end

	always_ff @(posedge clk) begin
		sr_s1 <= cr_q;
		sg_s1 <= cg_q;
		sb_s1 <= cb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIERS; t++) best_cnt_q[t] <= '0;
		end else if (cmd.scan_init) begin
			for (int t = 0; t < NUM_TIERS; t++) best_cnt_q[t] <= '0;
		end else if (sc_valid_s1) begin
			for (int t = 0; t < NUM_TIERS; t++) begin
				if (rd_q[t*COUNT_W +: COUNT_W] > best_cnt_q[t])
					best_cnt_q[t] <= rd_q[t*COUNT_W +: COUNT_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < NUM_TIERS; t++) begin
			if (sc_valid_s1 && rd_q[t*COUNT_W +: COUNT_W] > best_cnt_q[t]) begin
				best_r_q[t] <= sr_s1;
				best_g_q[t] <= sg_s1;
				best_b_q[t] <= sb_s1;
			end
		end
	end

	// ---------------- result
	result_t res;
	logic [QW-1:0] sel_r, sel_g, sel_b;

	always_comb begin
		res.tier_used = TIER_FALLBACK;
		sel_r = best_r_q[2];
		sel_g = best_g_q[2];
		sel_b = best_b_q[2];
		if (best_cnt_q[0] != '0) begin
			res.tier_used = TIER_STRICT;
			sel_r = best_r_q[0];
			sel_g = best_g_q[0];
			sel_b = best_b_q[0];
		end else if (best_cnt_q[1] != '0) begin
			res.tier_used = TIER_RELAXED;
			sel_r = best_r_q[1];
			sel_g = best_g_q[1];
			sel_b = best_b_q[1];
		end else if (best_cnt_q[2] != '0) begin
			res.tier_used = TIER_LOOSE;
		end
		if (res.tier_used == TIER_FALLBACK) begin
			res.out_red   = fallback_q[23:16];
			res.out_green = fallback_q[15:8];
			res.out_blue  = fallback_q[7:0];
		end else begin
			res.out_red   = 8'(MW'(sel_r) * MW'(BUCKET_STEP));
			res.out_green = 8'(MW'(sel_g) * MW'(BUCKET_STEP));
			res.out_blue  = 8'(MW'(sel_b) * MW'(BUCKET_STEP));
		end
	end

	logic    out_valid_q;
	result_t out_q;

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                     out_valid_q <= 1'b0;
		else if (cmd.out_load)           out_valid_q <= 1'b1;
		else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= res;
	end

endmodule

`default_nettype wire

### rtl/dominant_color_histogram_top.sv
// ----------------------------------------------------------------------------
// dominant_color_histogram_top
// Three-tier quantized RGB histogram that reports the dominant color per frame.
// ----------------------------------------------------------------------------
// Pixels stream in at one beat per cycle while in_stall is low; each one updates
// its bucket in a single-port-write bucket memory of (255/BUCKET_STEP+1)^3 words
// (1331 at the default step) through a read, increment, write loop with
// forwarding. After the beat marked last_pixel, intake stalls through a drain
// state for the final update, a scan that reads one bucket a cycle and zeroes
// it behind itself, a flush state that settles the maxima and a result state
// that loads the result register, holding off while an earlier result still
// waits in the output register. After reset the same memory is zeroed by a
// sweep pass before the first pixel is taken; configuration writes are taken
// at any time and apply to pixels that follow.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dominant_color_histogram_top_defines.svh"

module dominant_color_histogram_top
	import dch_pkg::*;
#(
	parameter int BUCKET_STEP = BUCKET_STEP_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire pixel_t               in_data,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      result_t              out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	dch_cmd_t cmd;
	dch_sts_t sts;
	logic     in_beat;

	assign in_beat = in_valid && !in_stall;

	dch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last_pixel),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	dch_datapath #(
		.BUCKET_STEP (BUCKET_STEP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	`DCH_ASSERT_NEXT(a_last_stall, in_beat && in_data.last_pixel, in_stall, "beat after last")
	`DCH_ASSERT(a_sweep_no_intake, cmd.sweep, in_stall, "beat during sweep")
	`DCH_ASSERT(a_load_when_free, cmd.out_load, !out_valid || !out_stall, "held result lost")

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dominant color histogram block. Streams RGB
// frames with random sender gaps and receiver stalls, mirrors the three-tier
// bucket histogram in a scoreboard and checks the color reported per frame.
// ----------------------------------------------------------------------------
module tb_top;
	import dch_pkg::*;

	localparam int STEP      = BUCKET_STEP_DEF;
	localparam int LEVELS    = 255 / STEP + 1;
	localparam int NBKT      = LEVELS * LEVELS * LEVELS;
	localparam int SETTLE    = 16;
	localparam int RAND_BEATS = 1080;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [1:0] TIER_CODE [NUM_TIERS] = '{TIER_STRICT, TIER_RELAXED, TIER_LOOSE};

	typedef enum {STALL_NONE, STALL_SOME, STALL_LONG} stall_mode_t;

	class color_scoreboard;
		logic [FLOOR_W-1:0] sat_floor [NUM_TIERS];
		logic [FLOOR_W-1:0] value_floor [NUM_TIERS];
		logic [COLOR_W-1:0] fallback;
		int unsigned        hist [NUM_TIERS][NBKT];
		result_t            dominant_q [$];
		int                 errors;

		function new();
			sat_floor   = '{STRICT_SAT_RST, RELAXED_SAT_RST, LOOSE_SAT_RST};
			value_floor = '{STRICT_VALUE_RST, RELAXED_VALUE_RST, LOOSE_VALUE_RST};
			fallback    = FALLBACK_RST;
			errors      = 0;
			clear_hist();
		endfunction

		function void clear_hist();
			for (int t = 0; t < NUM_TIERS; t++)
				for (int b = 0; b < NBKT; b++)
					hist[t][b] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (cfg_reg_t'(idx))
				CFG_STRICT_SAT:    sat_floor[0]   = data[FLOOR_W-1:0];
				CFG_STRICT_VALUE:  value_floor[0] = data[FLOOR_W-1:0];
				CFG_RELAXED_SAT:   sat_floor[1]   = data[FLOOR_W-1:0];
				CFG_RELAXED_VALUE: value_floor[1] = data[FLOOR_W-1:0];
				CFG_LOOSE_SAT:     sat_floor[2]   = data[FLOOR_W-1:0];
				CFG_LOOSE_VALUE:   value_floor[2] = data[FLOOR_W-1:0];
				CFG_FALLBACK:      fallback       = data[COLOR_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(pixel_t px);
			int unsigned mx, mn, bkt, best, best_n, qr, qg, qb;
			int          found;
			result_t     r;
			mx = px.red;
			mn = px.red;
			if (px.green > mx) mx = px.green;
			if (px.blue > mx)  mx = px.blue;
			if (px.green < mn) mn = px.green;
			if (px.blue < mn)  mn = px.blue;
			bkt = ((px.red / STEP) * LEVELS + px.green / STEP) * LEVELS + px.blue / STEP;
			for (int t = 0; t < NUM_TIERS; t++)
				if (mx * 1024 >= value_floor[t] * 255 && (mx - mn) * 1024 >= sat_floor[t] * mx
						&& hist[t][bkt] < COUNT_MAX)
					hist[t][bkt]++;
			if (!px.last_pixel)
				return;
			found  = -1;
			best   = 0;
			for (int t = 0; t < NUM_TIERS && found < 0; t++) begin
				best   = 0;
				best_n = 0;
				// strict compare keeps the lowest index on ties
				for (int b = 0; b < NBKT; b++)
					if (hist[t][b] > best_n) begin
						best_n = hist[t][b];
						best   = b;
					end
				if (best_n != 0)
					found = t;
			end
			if (found < 0) begin
				r.out_red   = fallback[23:16];
				r.out_green = fallback[15:8];
				r.out_blue  = fallback[7:0];
				r.tier_used = TIER_FALLBACK;
			end else begin
				qr = best / (LEVELS * LEVELS);
				qg = (best / LEVELS) % LEVELS;
				qb = best % LEVELS;
				r.out_red   = 8'(qr * STEP);
				r.out_green = 8'(qg * STEP);
				r.out_blue  = 8'(qb * STEP);
				r.tier_used = TIER_CODE[found];
			end
			dominant_q.push_back(r);
			clear_hist();
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (dominant_q.size() == 0) begin
				$error("result beat with nothing expected: %p", got);
				errors++;
				return;
			end
			want = dominant_q.pop_front();
			if (got.out_red !== want.out_red) begin
				$error("out_red expected %0d got %0d", want.out_red, got.out_red);
				errors++;
			end
			if (got.out_green !== want.out_green) begin
				$error("out_green expected %0d got %0d", want.out_green, got.out_green);
				errors++;
			end
			if (got.out_blue !== want.out_blue) begin
				$error("out_blue expected %0d got %0d", want.out_blue, got.out_blue);
				errors++;
			end
			if (got.tier_used !== want.tier_used) begin
				$error("tier_used expected %0d got %0d", want.tier_used, got.tier_used);
				errors++;
			end
		endfunction

		function int pending();
			return dominant_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	pixel_t               in_data;
	logic                 out_valid;
	logic                 out_stall;
	result_t              out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	color_scoreboard sb;
	int              burst_left;
	int              beats_sent;

	dominant_color_histogram_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_pixel(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
		end
	end

	// receiver stall pattern, switching mode after each random-length run
	initial begin
		stall_mode_t mode;
		int          run;
		int          hold;
		out_stall = 1'b0;
		mode      = STALL_NONE;
		run       = 0;
		hold      = 0;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				mode = stall_mode_t'($urandom_range(0, 2));
				run  = $urandom_range(50, 400);
			end
			run--;
			case (mode)
				STALL_NONE: out_stall = 1'b0;
				STALL_SOME: out_stall = ($urandom_range(0, 2) == 0);
				default: begin
					if (hold > 0) begin
						hold--;
						out_stall = 1'b1;
					end else if ($urandom_range(0, 9) == 0) begin
						hold      = $urandom_range(1, 30);
						out_stall = 1'b1;
					end else begin
						out_stall = 1'b0;
					end
				end
			endcase
		end
	end

	function automatic pixel_t mk_pixel(int r, int g, int b, bit last);
		pixel_t px;
		px.red        = 8'(r);
		px.green      = 8'(g);
		px.blue       = 8'(b);
		px.last_pixel = last;
		return px;
	endfunction

	function automatic logic [FLOOR_W-1:0] rand_floor();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 11'd1024;
			2:       return 11'($urandom_range(1025, 2047));
			default: return 11'($urandom_range(0, 420));
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the beat
	task automatic put_pixel(input pixel_t px);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		in_data  = px;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic write_floors(input logic [FLOOR_W-1:0] s0, v0, s1, v1, s2, v2);
		write_reg(CFG_STRICT_SAT, CFG_W'(s0));
		write_reg(CFG_STRICT_VALUE, CFG_W'(v0));
		write_reg(CFG_RELAXED_SAT, CFG_W'(s1));
		write_reg(CFG_RELAXED_VALUE, CFG_W'(v1));
		write_reg(CFG_LOOSE_SAT, CFG_W'(s2));
		write_reg(CFG_LOOSE_VALUE, CFG_W'(v2));
	endtask

	task automatic random_setting();
		logic [CFG_IDX_W-1:0] idx;
		for (int i = 0; i <= int'(CFG_UNUSED); i++) begin
			idx = CFG_IDX_W'(i);
			if ($urandom_range(0, 1) == 1) begin
				if (idx == CFG_FALLBACK)
					write_reg(idx, CFG_W'($urandom));
				else
					write_reg(idx, {13'($urandom), rand_floor()});
			end
		end
	endtask

	// a few dominant colors with jitter, plus noise
	task automatic random_frame();
		logic [23:0] palette [4];
		logic [23:0] base;
		logic [7:0]  mask;
		int          n_colors;
		int          len;
		pixel_t      px;
		n_colors = $urandom_range(1, 4);
		case ($urandom_range(0, 3))
			0:       mask = 8'h00;
			1:       mask = 8'h07;
			2:       mask = 8'h3F;
			default: mask = 8'hFF;
		endcase
		for (int k = 0; k < 4; k++)
			palette[k] = 24'($urandom);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				px = pixel_t'({24'($urandom), 1'b0});
			end else begin
				base     = palette[$urandom_range(0, n_colors - 1)];
				px.red   = base[23:16] ^ (8'($urandom) & mask);
				px.green = base[15:8] ^ (8'($urandom) & mask);
				px.blue  = base[7:0] ^ (8'($urandom) & mask);
			end
			px.last_pixel = (i == len - 1);
			put_pixel(px);
		end
	endtask

	initial begin
		sb         = new();
		burst_left = 0;
		beats_sent = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_STRICT_SAT;
		cfg_data   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset floors: fallback, strict tie, relaxed only, loose only, extremes
		put_pixel(mk_pixel(0, 0, 0, 1));
		put_pixel(mk_pixel(255, 255, 255, 0));
		put_pixel(mk_pixel(255, 0, 0, 0));
		put_pixel(mk_pixel(0, 0, 255, 1));
		put_pixel(mk_pixel(200, 140, 150, 1));
		put_pixel(mk_pixel(180, 200, 190, 1));
		put_pixel(mk_pixel(23, 24, 255, 0));
		put_pixel(mk_pixel(24, 23, 255, 0));
		put_pixel(mk_pixel(0, 255, 0, 0));
		put_pixel(mk_pixel(255, 0, 255, 0));
		put_pixel(mk_pixel(0, 255, 255, 1));
		wait_idle();

		// zero floors: black and grey pass every tier
		write_floors('0, '0, '0, '0, '0, '0);
		write_reg(CFG_FALLBACK, 24'hFFFFFF);
		put_pixel(mk_pixel(0, 0, 0, 1));
		put_pixel(mk_pixel(128, 128, 128, 0));
		put_pixel(mk_pixel(128, 128, 128, 0));
		put_pixel(mk_pixel(255, 255, 255, 1));
		wait_idle();

		// floors above full scale: nothing passes
		write_floors('1, '1, 11'd1025, 11'd1025, '1, 11'd1500);
		write_reg(CFG_FALLBACK, 24'h000000);
		write_reg(CFG_UNUSED, 24'hFFFFFF);
		put_pixel(mk_pixel(255, 0, 0, 1));
		wait_idle();

		// full-scale floors: only max 255 with min 0 passes
		write_floors(11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024);
		put_pixel(mk_pixel(254, 0, 0, 0));
		put_pixel(mk_pixel(255, 1, 0, 0));
		put_pixel(mk_pixel(255, 0, 0, 1));
		wait_idle();

		write_floors(STRICT_SAT_RST, STRICT_VALUE_RST, RELAXED_SAT_RST, RELAXED_VALUE_RST,
			LOOSE_SAT_RST, LOOSE_VALUE_RST);
		write_reg(CFG_FALLBACK, FALLBACK_RST);

		beats_sent = 0;
		while (beats_sent < RAND_BEATS) begin
			random_frame();
			if ($urandom_range(0, 5) == 0) begin
				wait_idle();
				random_setting();
			end else if ($urandom_range(0, 3) == 0) begin
				wait_idle();
			end
		end

		wait_idle();
		repeat (NBKT) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/dch_pkg.sv
rtl/dch_ctrl.sv
rtl/dch_datapath.sv
rtl/dominant_color_histogram_top.sv
sim/tb_top.sv
